// ----- sv/kpc_pkg.sv -----
// ----------------------------------------------------------------------------
// kpc_pkg
// types and constants shared by the key press classifier modules
// ----------------------------------------------------------------------------
package kpc_pkg;

  localparam int unsigned CNT_W  = 8;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_PRESS_LEVEL   = 3'd0,
    REG_MIN_PRESS     = 3'd1,
    REG_LONG_PRESS    = 3'd2,
    REG_HOLD_CAP      = 3'd3,
    REG_DOUBLE_WINDOW = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  localparam logic [CNT_W-1:0] MIN_PRESS_RST     = 8'd2;
  localparam logic [CNT_W-1:0] LONG_PRESS_RST    = 8'd100;
  localparam logic [CNT_W-1:0] HOLD_CAP_RST      = 8'd120;
  localparam logic [CNT_W-1:0] DOUBLE_WINDOW_RST = 8'd30;
  localparam logic [CNT_W-1:0] TALLY_MAX         = 8'd255;

  typedef struct packed {
    logic             press_level;
    logic [CNT_W-1:0] min_press_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] hold_cap_ticks;
    logic [CNT_W-1:0] double_window_ticks;
  } cfg_t;

endpackage

// ----- sv/key_press_classifier.sv -----
// ----------------------------------------------------------------------------
// key_press_classifier
// classifies button presses as single, double or long from sampled pin ticks
// ----------------------------------------------------------------------------
// an accepted tick beat gives its event beat in the following cycle
// throughput: one tick per cycle while the event register is not stalled, set by the single state update stage
// s_tready stays high while the event register is empty or being drained
// reset: synchronous, clears counters and the event register, loads defaults
module key_press_classifier (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [0] pin_level, [7:1] zero
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [7:0]                 m_tdata,   // [1:0] event_code, [7:2] zero
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kpc_pkg::ADDR_W-1:0] paddr,
  input  logic [kpc_pkg::DATA_W-1:0] pwdata,
  output logic [kpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  kpc_pkg::cfg_t cfg;
  logic [1:0]    event_code;

  kpc_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kpc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .pin_level  (s_tdata[0]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .event_code (event_code)
  );

  assign m_tdata = {6'b0, event_code};

endmodule

// ----- sv/kpc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// kpc_cfg_regs
// apb register file holding the classifier thresholds
// ----------------------------------------------------------------------------
module kpc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [kpc_pkg::DATA_W-1:0]  pwdata,
  output logic [kpc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output kpc_pkg::cfg_t               cfg
);

  logic     wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[kpc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_level         <= 1'b0;
      cfg.min_press_ticks     <= kpc_pkg::MIN_PRESS_RST;
      cfg.long_press_ticks    <= kpc_pkg::LONG_PRESS_RST;
      cfg.hold_cap_ticks      <= kpc_pkg::HOLD_CAP_RST;
      cfg.double_window_ticks <= kpc_pkg::DOUBLE_WINDOW_RST;
    end else if (wr_en) begin
      case (idx)
        kpc_pkg::REG_PRESS_LEVEL:   cfg.press_level         <= pwdata[0];
        kpc_pkg::REG_MIN_PRESS:     cfg.min_press_ticks     <= pwdata[7:0];
        kpc_pkg::REG_LONG_PRESS:    cfg.long_press_ticks    <= pwdata[7:0];
        kpc_pkg::REG_HOLD_CAP:      cfg.hold_cap_ticks      <= pwdata[7:0];
        kpc_pkg::REG_DOUBLE_WINDOW: cfg.double_window_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      kpc_pkg::REG_PRESS_LEVEL:   prdata[0]   = cfg.press_level;
      kpc_pkg::REG_MIN_PRESS:     prdata[7:0] = cfg.min_press_ticks;
      kpc_pkg::REG_LONG_PRESS:    prdata[7:0] = cfg.long_press_ticks;
      kpc_pkg::REG_HOLD_CAP:      prdata[7:0] = cfg.hold_cap_ticks;
      kpc_pkg::REG_DOUBLE_WINDOW: prdata[7:0] = cfg.double_window_ticks;
      default: prdata = '0;
    endcase
  end

endmodule

// ----- sv/kpc_core.sv -----
// ----------------------------------------------------------------------------
// kpc_core
// per-tick hold, window and tally update with a registered event output
// ----------------------------------------------------------------------------
module kpc_core (
  input  logic                    clk,
  input  logic                    rst,
  input  kpc_pkg::cfg_t           cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    pin_level,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              event_code
);

  logic [kpc_pkg::CNT_W-1:0] hold_ticks, hold_ticks_next;
  logic [kpc_pkg::CNT_W-1:0] window_ticks, window_ticks_next;
  logic [kpc_pkg::CNT_W-1:0] press_tally, press_tally_next;
  logic                      long_blocked, long_blocked_next;
  kpc_pkg::event_t           ev;
  logic [kpc_pkg::CNT_W:0]   hold_inc;
  logic [kpc_pkg::CNT_W-1:0] win_tmp;
  logic                      accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign hold_inc = {1'b0, hold_ticks} + {{kpc_pkg::CNT_W{1'b0}}, 1'b1};

  always_comb begin
    hold_ticks_next   = hold_ticks;
    window_ticks_next = window_ticks;
    press_tally_next  = press_tally;
    long_blocked_next = long_blocked;
    ev                = kpc_pkg::EV_NONE;
    win_tmp           = window_ticks;
    if (pin_level == cfg.press_level) begin
      if (hold_inc >= {1'b0, cfg.hold_cap_ticks}) begin
        hold_ticks_next = cfg.hold_cap_ticks;
      end else begin
        hold_ticks_next = hold_inc[kpc_pkg::CNT_W-1:0];
      end
    end else begin
      if (hold_ticks >= cfg.long_press_ticks && !long_blocked) begin
        ev = kpc_pkg::EV_LONG;
      end else if (hold_ticks >= cfg.min_press_ticks) begin
        if (press_tally != kpc_pkg::TALLY_MAX) begin
          press_tally_next = press_tally + 1'b1;
        end
        win_tmp           = cfg.double_window_ticks;
        long_blocked_next = 1'b1;
      end
      hold_ticks_next   = '0;
      window_ticks_next = win_tmp;
      if (win_tmp != '0) begin
        window_ticks_next = win_tmp - 1'b1;
        if (win_tmp == {{(kpc_pkg::CNT_W-1){1'b0}}, 1'b1}) begin
          if (press_tally_next == 8'd1) begin
            ev = kpc_pkg::EV_SINGLE;
          end else if (press_tally_next == 8'd2) begin
            ev = kpc_pkg::EV_DOUBLE;
          end
          press_tally_next  = '0;
          long_blocked_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks   <= '0;
      window_ticks <= '0;
      press_tally  <= '0;
      long_blocked <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        hold_ticks   <= hold_ticks_next;
        window_ticks <= window_ticks_next;
        press_tally  <= press_tally_next;
        long_blocked <= long_blocked_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_code <= ev;
    end
  end

endmodule

// ----- sv/kpc_checker.sv -----
// ----------------------------------------------------------------------------
// kpc_checker
// port-level checks for the key press classifier
// ----------------------------------------------------------------------------
module kpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // stalled event beat keeps its data
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("event beat changed while stalled");

  // input side is open whenever the event register can take a beat
  assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output space");

  // every accepted tick yields an event beat next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted tick gave no event beat");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("event beat valid after reset");

  // padding bits stay zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:2] == 6'b0)
    else $error("event padding not zero");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/sv/key_press_classifier_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_press_classifier_tb
// streams pin ticks through the classifier under several register settings,
// predicts each event code with a local copy of the press state machine and
// compares every event beat in order; registers are written and read back
// over the bus between phases while the stream is drained
// ----------------------------------------------------------------------------
module key_press_classifier_tb;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [kpc_pkg::ADDR_W-1:0] SPARE_ADDR = 5'd20;
  localparam int unsigned RANDOM_PHASES = 4;
  localparam int unsigned TICKS_PER_PHASE = 100;

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [7:0]                 s_tdata  = 8'd0;  // [0] pin_level, [7:1] zero
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [7:0]                 m_tdata;          // [1:0] event_code, [7:2] zero
  logic                       psel     = 1'b0;
  logic                       penable  = 1'b0;
  logic                       pwrite   = 1'b0;
  logic [kpc_pkg::ADDR_W-1:0] paddr    = '0;
  logic [kpc_pkg::DATA_W-1:0] pwdata   = '0;
  logic [kpc_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  key_press_classifier dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  logic            pin_queue[$];
  kpc_pkg::event_t event_queue[$];

  kpc_pkg::cfg_t cfg_shadow = '{1'b0, kpc_pkg::MIN_PRESS_RST, kpc_pkg::LONG_PRESS_RST,
                                kpc_pkg::HOLD_CAP_RST, kpc_pkg::DOUBLE_WINDOW_RST};
  logic [7:0]  hold_cnt   = 8'd0;
  logic [7:0]  window_cnt = 8'd0;
  logic [7:0]  tally      = 8'd0;
  logic        long_lock  = 1'b0;

  int unsigned errors         = 0;
  int unsigned stall_cnt      = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        tick_taken     = 1'b0;

  function automatic kpc_pkg::event_t classify_tick(input logic pin);
    kpc_pkg::event_t ev;
    ev = kpc_pkg::EV_NONE;
    if (pin == cfg_shadow.press_level) begin
      if ({1'b0, hold_cnt} + 9'd1 >= {1'b0, cfg_shadow.hold_cap_ticks}) begin
        hold_cnt = cfg_shadow.hold_cap_ticks;
      end else begin
        hold_cnt = hold_cnt + 8'd1;
      end
    end else begin
      if (hold_cnt >= cfg_shadow.long_press_ticks && !long_lock) begin
        ev = kpc_pkg::EV_LONG;
      end else if (hold_cnt >= cfg_shadow.min_press_ticks) begin
        if (tally != kpc_pkg::TALLY_MAX) tally = tally + 8'd1;
        window_cnt = cfg_shadow.double_window_ticks;
        long_lock  = 1'b1;
      end
      hold_cnt = 8'd0;
      if (window_cnt != 8'd0) begin
        window_cnt = window_cnt - 8'd1;
        if (window_cnt == 8'd0) begin
          if (tally == 8'd1) begin
            ev = kpc_pkg::EV_SINGLE;
          end else if (tally == 8'd2) begin
            ev = kpc_pkg::EV_DOUBLE;
          end
          tally     = 8'd0;
          long_lock = 1'b0;
        end
      end
    end
    return ev;
  endfunction

  function automatic logic [kpc_pkg::ADDR_W-1:0] reg_addr(input kpc_pkg::reg_idx_t r);
    return {r, 2'b00};
  endfunction

  // tick driver and event receiver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || tick_taken) begin
        if (pin_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, pin_queue[0]};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    kpc_pkg::event_t want;
    if (rst) begin
      tick_taken <= 1'b0;
    end else begin
      tick_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        event_queue.push_back(classify_tick(s_tdata[0]));
        void'(pin_queue.pop_front());
      end
      if (m_tvalid && m_tready) begin
        if (event_queue.size() == 0) begin
          $display("%0t: unexpected event beat, expected none actual %0d", $time, m_tdata);
          errors++;
        end else begin
          want = event_queue.pop_front();
          if (m_tdata !== {6'd0, want}) begin
            $display("%0t: event_code mismatch, expected %0d actual %0d",
                     $time, want, m_tdata);
            errors++;
          end
        end
      end
      if (!(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
        stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles", $time, stall_cnt);
          $display("== FAIL ==");
          $finish;
        end
      end else begin
        stall_cnt = 0;
      end
    end
  end

  task automatic apb_write(input logic [kpc_pkg::ADDR_W-1:0] addr,
                           input logic [kpc_pkg::DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input kpc_pkg::reg_idx_t r, input logic [kpc_pkg::DATA_W-1:0] want);
    logic [kpc_pkg::DATA_W-1:0] got;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_addr(r);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $display("%0t: register %s readback mismatch, expected %0d actual %0d",
               $time, r.name(), want, got);
      errors++;
    end
  endtask

  task automatic load_settings(input logic pl, input logic [7:0] mn, input logic [7:0] lg,
                               input logic [7:0] cap, input logic [7:0] win);
    apb_write(reg_addr(kpc_pkg::REG_PRESS_LEVEL), 32'(pl));
    apb_write(reg_addr(kpc_pkg::REG_MIN_PRESS), 32'(mn));
    apb_write(reg_addr(kpc_pkg::REG_LONG_PRESS), 32'(lg));
    apb_write(reg_addr(kpc_pkg::REG_HOLD_CAP), 32'(cap));
    apb_write(reg_addr(kpc_pkg::REG_DOUBLE_WINDOW), 32'(win));
    // unmapped address, must leave every register alone
    apb_write(SPARE_ADDR, $urandom);
    check_reg(kpc_pkg::REG_PRESS_LEVEL, 32'(pl));
    check_reg(kpc_pkg::REG_MIN_PRESS, 32'(mn));
    check_reg(kpc_pkg::REG_LONG_PRESS, 32'(lg));
    check_reg(kpc_pkg::REG_HOLD_CAP, 32'(cap));
    check_reg(kpc_pkg::REG_DOUBLE_WINDOW, 32'(win));
    cfg_shadow.press_level         = pl;
    cfg_shadow.min_press_ticks     = mn;
    cfg_shadow.long_press_ticks    = lg;
    cfg_shadow.hold_cap_ticks      = cap;
    cfg_shadow.double_window_ticks = win;
  endtask

  task automatic add_press(input int unsigned held, input int unsigned released);
    repeat (held) pin_queue.push_back(cfg_shadow.press_level);
    repeat (released) pin_queue.push_back(~cfg_shadow.press_level);
  endtask

  task automatic wait_drained();
    while (pin_queue.size() != 0 || event_queue.size() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned send_pcts [4];
    int unsigned recv_pcts [4];
    int unsigned count;
    int unsigned held;
    int unsigned released;
    logic [7:0]  mn;
    logic [7:0]  lg;
    logic [7:0]  cap;
    logic [7:0]  win;

    send_pcts = '{0, 54, 0, 24};
    recv_pcts = '{0, 0, 54, 24};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults out of reset
    check_reg(kpc_pkg::REG_PRESS_LEVEL, 32'd0);
    check_reg(kpc_pkg::REG_MIN_PRESS, 32'(kpc_pkg::MIN_PRESS_RST));
    check_reg(kpc_pkg::REG_LONG_PRESS, 32'(kpc_pkg::LONG_PRESS_RST));
    check_reg(kpc_pkg::REG_HOLD_CAP, 32'(kpc_pkg::HOLD_CAP_RST));
    check_reg(kpc_pkg::REG_DOUBLE_WINDOW, 32'(kpc_pkg::DOUBLE_WINDOW_RST));
    add_press(3, 2);
    add_press(101, 1);
    wait_drained();

    // small thresholds: window and lock left from the last phase, double, triple, short hold, capped long, blocked long
    load_settings(1'b1, 8'd2, 8'd6, 8'd8, 8'd4);
    add_press(0, 2);
    add_press(7, 1);
    add_press(2, 4);
    add_press(3, 1);
    add_press(2, 4);
    add_press(2, 1);
    add_press(2, 1);
    add_press(2, 4);
    add_press(1, 1);
    add_press(20, 1);
    add_press(2, 1);
    add_press(7, 4);
    wait_drained();

    // zero cap and zero long threshold: every released tick is a long press
    load_settings(1'b0, 8'd0, 8'd0, 8'd0, 8'd1);
    add_press(3, 3);
    add_press(0, 2);
    wait_drained();

    // zero minimum and zero window: tally runs into saturation, lock stays
    load_settings(1'b1, 8'd0, 8'd255, 8'd255, 8'd0);
    add_press(0, 260);
    add_press(260, 1);
    wait_drained();

    // short window: saturated tally expires with no event, then single and long
    load_settings(1'b0, 8'd1, 8'd255, 8'd255, 8'd4);
    add_press(1, 5);
    add_press(1, 4);
    add_press(255, 1);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      send_idle_pct  = send_pcts[p % 4];
      recv_stall_pct = recv_pcts[p % 4];
      mn  = 8'($urandom_range(1, 4));
      lg  = 8'($urandom_range(1, 12));
      cap = 8'($urandom_range(1, 16));
      win = 8'($urandom_range(1, 8));
      load_settings(1'($urandom_range(1)), mn, lg, cap, win);
      count = 0;
      while (count < TICKS_PER_PHASE) begin
        if ($urandom_range(9) < 8) begin
          held     = $urandom_range(cap + 2);
          released = ($urandom_range(3) == 0) ? $urandom_range(1, win + 3)
                                              : $urandom_range(1, 3);
          add_press(held, released);
          count += held + released;
        end else begin
          held = $urandom_range(1, 6);
          repeat (held) pin_queue.push_back(1'($urandom_range(1)));
          count += held;
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
